// ----- rtl/led_scanner_eye_sweep_assert.svh -----
// assertion macros for the led scanner block
// no dependencies; taken in by the modules that check their own logic
`ifndef LED_SCANNER_EYE_SWEEP_ASSERT_SVH
`define LED_SCANNER_EYE_SWEEP_ASSERT_SVH
`ifndef SYNTHESIS
`define LSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LSE_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSE_ASSERT(lbl, clk, rst, prop, msg)
`define LSE_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/lse_pkg.sv -----
// shared types, codes and helper functions for the led scanner
// no dependencies
package lse_pkg;

   localparam int STRIP_LEDS_DEF = 16;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;

   // register indexes
   localparam logic [2:0] REG_EYE_RED    = 3'd0;
   localparam logic [2:0] REG_EYE_GREEN  = 3'd1;
   localparam logic [2:0] REG_EYE_BLUE   = 3'd2;
   localparam logic [2:0] REG_EYE_WIDTH  = 3'd3;
   localparam logic [2:0] REG_STEP_WAIT  = 3'd4;
   localparam logic [2:0] REG_SWEEP_WAIT = 3'd5;

   // sweep kinds
   localparam logic [1:0] KIND_R2L = 2'd0;
   localparam logic [1:0] KIND_L2R = 2'd1;
   localparam logic [1:0] KIND_O2C = 2'd2;
   localparam logic [1:0] KIND_C2O = 2'd3;

   // wait phases
   localparam logic [1:0] PH_FRAME = 2'd0;
   localparam logic [1:0] PH_STEP  = 2'd1;
   localparam logic [1:0] PH_SWEEP = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_LOAD       = 4'd1;
   localparam logic [3:0] OP_START      = 4'd2;
   localparam logic [3:0] OP_FRAME      = 4'd3;
   localparam logic [3:0] OP_DEC        = 4'd4;
   localparam logic [3:0] OP_ADVANCE    = 4'd5;
   localparam logic [3:0] OP_SWEEP_WAIT = 4'd6;
   localparam logic [3:0] OP_ENTER_OK   = 4'd7;
   localparam logic [3:0] OP_NEXT_SWEEP = 4'd8;
   localparam logic [3:0] OP_PIXEL      = 4'd9;
   localparam logic [3:0] OP_DONE       = 4'd10;

   typedef struct packed {
      logic [7:0] eye_red;
      logic [7:0] eye_green;
      logic [7:0] eye_blue;
      logic [5:0] eye_width;
      logic [7:0] step_wait;
      logic [7:0] sweep_wait;
   } cfg_type;

   typedef struct packed {
      logic [3:0] op;
   } ctl_cmd_type;

   typedef struct packed {
      logic       item_cmd;
      logic       item_abort;
      logic       busy;
      logic [1:0] phase;
      logic       count_gt1;
      logic       adv_ok;
      logic       start_ok;
      logic       sweep_wait_nz;
      logic       last_sweep;
      logic       last_pix;
      logic       out_free;
   } ctl_status_type;

   function automatic logic [1:0] sweep_kind(input logic [2:0] num);
      logic [1:0] k;
      case (num)
         3'd0:    k = KIND_R2L;
         3'd1:    k = KIND_L2R;
         3'd2:    k = KIND_O2C;
         3'd3:    k = KIND_C2O;
         3'd4:    k = KIND_L2R;
         3'd5:    k = KIND_R2L;
         3'd6:    k = KIND_O2C;
         default: k = KIND_C2O;
      endcase
      return k;
   endfunction

   // exact x/10 for 8-bit x
   function automatic logic [7:0] div10(input logic [7:0] x);
      logic [15:0] pr;
      pr = 16'(x) * 16'd205;
      return {3'b000, pr[15:11]};
   endfunction

endpackage

// ----- rtl/lse_csr.sv -----
// configuration register file of the led scanner, apb-style access
// depends on lse_pkg
module lse_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lse_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lse_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output lse_pkg::cfg_type               cfg
);

   lse_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            lse_pkg::REG_EYE_RED:    cfg_in.eye_red    = csr_pwdata[7:0];
            lse_pkg::REG_EYE_GREEN:  cfg_in.eye_green  = csr_pwdata[7:0];
            lse_pkg::REG_EYE_BLUE:   cfg_in.eye_blue   = csr_pwdata[7:0];
            lse_pkg::REG_EYE_WIDTH:  cfg_in.eye_width  = csr_pwdata[5:0];
            lse_pkg::REG_STEP_WAIT:  cfg_in.step_wait  = csr_pwdata[7:0];
            lse_pkg::REG_SWEEP_WAIT: cfg_in.sweep_wait = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         lse_pkg::REG_EYE_RED:    csr_prdata = 32'(cfg_ff.eye_red);
         lse_pkg::REG_EYE_GREEN:  csr_prdata = 32'(cfg_ff.eye_green);
         lse_pkg::REG_EYE_BLUE:   csr_prdata = 32'(cfg_ff.eye_blue);
         lse_pkg::REG_EYE_WIDTH:  csr_prdata = 32'(cfg_ff.eye_width);
         lse_pkg::REG_STEP_WAIT:  csr_prdata = 32'(cfg_ff.step_wait);
         lse_pkg::REG_SWEEP_WAIT: csr_prdata = 32'(cfg_ff.sweep_wait);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eye_red    <= 8'd255;
         cfg_ff.eye_green  <= 8'd0;
         cfg_ff.eye_blue   <= 8'd0;
         cfg_ff.eye_width  <= 6'd4;
         cfg_ff.step_wait  <= 8'd10;
         cfg_ff.sweep_wait <= 8'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/lse_ctrl.sv -----
// sequencing state machine of the led scanner
// depends on lse_pkg and the assertion macro header
`include "led_scanner_eye_sweep_assert.svh"
module lse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lse_pkg::ctl_status_type st,
   output lse_pkg::ctl_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_ENTER = 3'd2;
   localparam logic [2:0] S_END   = 3'd3;
   localparam logic [2:0] S_FRAME = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = lse_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = lse_pkg::OP_LOAD;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (st.item_cmd) begin
               if (!st.busy) begin
                  cmd.op   = lse_pkg::OP_START;
                  state_in = S_ENTER;
               end
            end else if (st.busy) begin
               if (st.phase == lse_pkg::PH_FRAME) begin
                  cmd.op   = lse_pkg::OP_FRAME;
                  state_in = S_FRAME;
               end else if (st.count_gt1) begin
                  cmd.op = lse_pkg::OP_DEC;
               end else if (st.phase != lse_pkg::PH_STEP || st.item_abort) begin
                  state_in = S_END;
               end else if (st.adv_ok) begin
                  cmd.op = lse_pkg::OP_ADVANCE;
               end else if (st.sweep_wait_nz) begin
                  cmd.op = lse_pkg::OP_SWEEP_WAIT;
               end else begin
                  state_in = S_END;
               end
            end
         end
         S_ENTER: begin
            state_in = S_IDLE;
            if (st.start_ok) begin
               cmd.op = lse_pkg::OP_ENTER_OK;
            end else if (st.sweep_wait_nz) begin
               cmd.op = lse_pkg::OP_SWEEP_WAIT;
            end else begin
               state_in = S_END;
            end
         end
         S_END: begin
            if (st.last_sweep) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = lse_pkg::OP_NEXT_SWEEP;
               state_in = S_ENTER;
            end
         end
         S_FRAME: begin
            if (st.out_free) begin
               cmd.op = lse_pkg::OP_PIXEL;
               if (st.last_pix) state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.op   = lse_pkg::OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LSE_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == S_IDLE), "not idle after reset")
   `LSE_ASSERT(a_frame_hold, clock, reset, (state_ff == S_FRAME && !st.out_free) |=> (state_ff == S_FRAME), "frame left while output stalled")
   `LSE_ASSERT(a_eval_once, clock, reset, (state_ff == S_EVAL) |=> (state_ff != S_EVAL), "item evaluated twice")
   `LSE_ASSERT(a_last_done, clock, reset, (state_ff == S_END && st.last_sweep) |=> (state_ff == S_DONE), "eighth sweep end without done beat")

endmodule

// ----- rtl/lse_dp.sv -----
// datapath of the led scanner: sweep state, pixel shading and result register
// depends on lse_pkg and the assertion macro header
`include "led_scanner_eye_sweep_assert.svh"
module lse_dp #(
   parameter int STRIP_LEDS = lse_pkg::STRIP_LEDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lse_pkg::cfg_type        cfg,
   input  lse_pkg::ctl_cmd_type    cmd,
   output lse_pkg::ctl_status_type st,
   input  logic                    item_cmd,
   input  logic                    item_abort,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tlast,
   output logic                    rsp_tuser
);

   localparam int PIX_W = (STRIP_LEDS > 1) ? $clog2(STRIP_LEDS) : 1;
   localparam logic signed [8:0] STRIP_S = 9'(STRIP_LEDS);
   localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(STRIP_LEDS - 1);
   localparam logic [PIX_W-1:0] PIX_ONE  = PIX_W'(1);

   logic             cmd_ff, abort_ff;
   logic             busy_ff, busy_in;
   logic [2:0]       sweep_ff, sweep_in;
   logic [7:0]       pos_ff, pos_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       count_ff, count_in;
   logic [PIX_W-1:0] pix_ff, pix_in;

   logic             valid_ff, valid_in;
   logic [5:0]       idx_ff, idx_in;
   logic [7:0]       red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic             last_ff, last_in, done_ff, done_in;

   logic [1:0]        kind;
   logic signed [8:0] width_s, span_s, half_s, pos_s, start_p, adv_p;
   logic signed [8:0] m_s, d1, d2, e1;
   logic              mirror, in1, full1, in2, full2;
   logic [7:0]        dim_r, dim_g, dim_b;

   function automatic logic pos_ok(input logic [1:0] k, input logic signed [8:0] p,
                                   input logic signed [8:0] n, input logic signed [8:0] nh);
      logic ok;
      case (k)
         lse_pkg::KIND_R2L: ok = (p > 9'sd0);
         lse_pkg::KIND_L2R: ok = (p >= 9'sd0) && (p < n - 9'sd2);
         lse_pkg::KIND_O2C: ok = (p >= 9'sd0) && (p <= nh);
         default:           ok = (p >= 9'sd0);
      endcase
      return ok;
   endfunction

   // sweep bounds
   assign kind    = lse_pkg::sweep_kind(sweep_ff);
   assign width_s = signed'({3'b000, cfg.eye_width});
   assign span_s  = STRIP_S - width_s;
   assign half_s  = (span_s + signed'({8'd0, span_s[8]})) >>> 1;
   assign pos_s   = signed'({1'b0, pos_ff});

   always_comb begin
      case (kind)
         lse_pkg::KIND_R2L: start_p = span_s - 9'sd2;
         lse_pkg::KIND_C2O: start_p = half_s;
         default:           start_p = 9'sd0;
      endcase
   end

   assign adv_p = (kind == lse_pkg::KIND_R2L || kind == lse_pkg::KIND_C2O) ?
                  pos_s - 9'sd1 : pos_s + 9'sd1;

   // pixel shading, mirrored eye wins
   assign m_s    = signed'(9'(pix_ff));
   assign e1     = width_s + 9'sd1;
   assign d1     = m_s - pos_s;
   assign d2     = STRIP_S - pos_s - m_s;
   assign mirror = (kind == lse_pkg::KIND_O2C || kind == lse_pkg::KIND_C2O);
   assign in1    = (d1 >= 9'sd0) && (d1 <= e1);
   assign full1  = (d1 >= 9'sd1) && (d1 <= width_s);
   assign in2    = mirror && (d2 >= 9'sd0) && (d2 <= e1);
   assign full2  = (d2 >= 9'sd1) && (d2 <= width_s);
   assign dim_r  = lse_pkg::div10(cfg.eye_red);
   assign dim_g  = lse_pkg::div10(cfg.eye_green);
   assign dim_b  = lse_pkg::div10(cfg.eye_blue);

   // status
   assign st.item_cmd      = cmd_ff;
   assign st.item_abort    = abort_ff;
   assign st.busy          = busy_ff;
   assign st.phase         = phase_ff;
   assign st.count_gt1     = (count_ff > 8'd1);
   assign st.adv_ok        = pos_ok(kind, adv_p, span_s, half_s);
   assign st.start_ok      = pos_ok(kind, start_p, span_s, half_s);
   assign st.sweep_wait_nz = (cfg.sweep_wait != 8'd0);
   assign st.last_sweep    = (sweep_ff == 3'd7);
   assign st.last_pix      = (pix_ff == PIX_LAST);
   assign st.out_free      = !valid_ff || rsp_tready;

   always_comb begin
      busy_in  = busy_ff;
      sweep_in = sweep_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      pix_in   = pix_ff;
      valid_in = valid_ff & ~rsp_tready;
      idx_in   = idx_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      case (cmd.op)
         lse_pkg::OP_START: begin
            busy_in  = 1'b1;
            sweep_in = 3'd0;
         end
         lse_pkg::OP_FRAME: begin
            phase_in = lse_pkg::PH_STEP;
            count_in = cfg.step_wait;
            pix_in   = '0;
         end
         lse_pkg::OP_DEC: count_in = count_ff - 8'd1;
         lse_pkg::OP_ADVANCE: begin
            pos_in   = adv_p[7:0];
            phase_in = lse_pkg::PH_FRAME;
            count_in = 8'd0;
         end
         lse_pkg::OP_SWEEP_WAIT: begin
            pos_in   = 8'd0;
            phase_in = lse_pkg::PH_SWEEP;
            count_in = cfg.sweep_wait;
         end
         lse_pkg::OP_ENTER_OK: begin
            pos_in   = start_p[7:0];
            phase_in = lse_pkg::PH_FRAME;
            count_in = 8'd0;
         end
         lse_pkg::OP_NEXT_SWEEP: sweep_in = sweep_ff + 3'd1;
         lse_pkg::OP_PIXEL: begin
            valid_in = 1'b1;
            idx_in   = 6'(pix_ff);
            last_in  = (pix_ff == PIX_LAST);
            done_in  = 1'b0;
            pix_in   = pix_ff + PIX_ONE;
            if (in2) begin
               red_in   = full2 ? cfg.eye_red   : dim_r;
               green_in = full2 ? cfg.eye_green : dim_g;
               blue_in  = full2 ? cfg.eye_blue  : dim_b;
            end else if (in1) begin
               red_in   = full1 ? cfg.eye_red   : dim_r;
               green_in = full1 ? cfg.eye_green : dim_g;
               blue_in  = full1 ? cfg.eye_blue  : dim_b;
            end else begin
               red_in   = 8'd0;
               green_in = 8'd0;
               blue_in  = 8'd0;
            end
         end
         lse_pkg::OP_DONE: begin
            valid_in = 1'b1;
            idx_in   = 6'd0;
            red_in   = 8'd0;
            green_in = 8'd0;
            blue_in  = 8'd0;
            last_in  = 1'b1;
            done_in  = 1'b1;
            busy_in  = 1'b0;
            sweep_in = 3'd0;
            pos_in   = 8'd0;
            phase_in = lse_pkg::PH_FRAME;
            count_in = 8'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lse_pkg::OP_LOAD) begin
         cmd_ff   <= item_cmd;
         abort_ff <= item_abort;
      end
      idx_ff   <= idx_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         sweep_ff <= 3'd0;
         pos_ff   <= 8'd0;
         phase_ff <= lse_pkg::PH_FRAME;
         count_ff <= 8'd0;
         pix_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         pix_ff   <= pix_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, blue_ff, green_ff, red_ff, idx_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

   `LSE_ASSERT(a_done_idle, clock, reset, (cmd.op == lse_pkg::OP_DONE) |=> (!busy_ff && done_ff && valid_ff), "done beat did not end the sequence")

endmodule

// ----- rtl/led_scanner_eye_sweep.sv -----
// top level of the led scanner eye sweep block
// depends on lse_pkg, lse_csr, lse_ctrl and lse_dp
//
//   channel   dir   beat contents
//   req_      in    tuser: cmd; tdata[0]: abort
//   rsp_      out   tdata: led_index, pix_red, pix_green, pix_blue; tlast; tuser: done
//   csr_      in    apb-style register access, six registers at 4*i
//
// a tick that draws a frame sends STRIP_LEDS pixel beats, one pixel beat per cycle while the output is not stalled
// a tick that only counts down, steps the eye or is ignored passes through S_EVAL, a start also through S_ENTER
// ending a sweep passes through S_END and S_ENTER for each sweep entered or passed over after it
// after the eighth sweep it goes from S_END to S_DONE, which sends the done beat
// pixel and done beats pause while rsp_tready is low; one beat may wait in the output stage
// synchronous reset, no clearing pass
module led_scanner_eye_sweep #(
   parameter int STRIP_LEDS = lse_pkg::STRIP_LEDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] abort
   input  logic                           req_tuser,   // [0] cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // led_index, red, green, blue
   output logic                           rsp_tlast,
   output logic                           rsp_tuser,   // [0] sequence_done
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lse_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lse_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   lse_pkg::cfg_type        cfg;
   lse_pkg::ctl_cmd_type    cmd;
   lse_pkg::ctl_status_type st;

   lse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   lse_dp #(
      .STRIP_LEDS (STRIP_LEDS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .st         (st),
      .item_cmd   (req_tuser),
      .item_abort (req_tdata[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- sim/tb_led_scanner_eye_sweep.sv -----
// testbench for led_scanner_eye_sweep: predicts every pixel and done beat of the scanner
// and checks them beat by beat under random stalls on both stream sides
// depends on lse_pkg and the led_scanner_eye_sweep rtl

typedef struct packed {
   logic [5:0] led_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;
   logic       seq_done;
} pixel_beat_type;

class sweep_scoreboard;
   localparam int LEDS = lse_pkg::STRIP_LEDS_DEF;

   logic [7:0] red = 8'd255;
   logic [7:0] green = 8'd0;
   logic [7:0] blue = 8'd0;
   logic [5:0] width = 6'd4;
   logic [7:0] step_len = 8'd10;
   logic [7:0] sweep_len = 8'd50;

   bit         busy;
   logic [2:0] sweep_num;
   logic [7:0] eye_pos;
   logic [1:0] phase = lse_pkg::PH_FRAME;
   logic [7:0] count;

   logic [1:0] sweep_order [8] = '{lse_pkg::KIND_R2L, lse_pkg::KIND_L2R, lse_pkg::KIND_O2C,
                                   lse_pkg::KIND_C2O, lse_pkg::KIND_L2R, lse_pkg::KIND_R2L,
                                   lse_pkg::KIND_O2C, lse_pkg::KIND_C2O};
   logic [7:0] fr_r [LEDS];
   logic [7:0] fr_g [LEDS];
   logic [7:0] fr_b [LEDS];

   pixel_beat_type pixels_due[$];
   int n_items, n_beats, n_frames, n_done, n_aborts, n_errors;

   function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
         lse_pkg::REG_EYE_RED:    red = val;
         lse_pkg::REG_EYE_GREEN:  green = val;
         lse_pkg::REG_EYE_BLUE:   blue = val;
         lse_pkg::REG_EYE_WIDTH:  width = val[5:0];
         lse_pkg::REG_STEP_WAIT:  step_len = val;
         lse_pkg::REG_SWEEP_WAIT: sweep_len = val;
         default: ;
      endcase
   endfunction

   function int pending();
      return pixels_due.size();
   endfunction

   function int span();
      return LEDS - int'(width);
   endfunction

   function logic [1:0] kind();
      return sweep_order[sweep_num];
   endfunction

   function bit fits(logic [1:0] k, int p);
      int n;
      n = span();
      case (k)
         lse_pkg::KIND_R2L: return p > 0;
         lse_pkg::KIND_L2R: return p >= 0 && p < n - 2;
         lse_pkg::KIND_O2C: return p >= 0 && p <= n / 2;
         default:           return p >= 0;
      endcase
   endfunction

   // false when the sweep is empty and has no sweep wait
   function bit open_sweep();
      int p;
      p = 0;
      if (kind() == lse_pkg::KIND_R2L) p = span() - 2;
      else if (kind() == lse_pkg::KIND_C2O) p = span() / 2;
      if (fits(kind(), p)) begin
         eye_pos = 8'(p);
         phase = lse_pkg::PH_FRAME;
         count = 8'd0;
         return 1'b1;
      end
      eye_pos = 8'd0;
      if (sweep_len != 8'd0) begin
         phase = lse_pkg::PH_SWEEP;
         count = sweep_len;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void close_sweep();
      pixel_beat_type b;
      while (1'b1) begin
         if (sweep_num == 3'd7) begin
            b = '{6'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1};
            pixels_due.push_back(b);
            busy = 1'b0;
            sweep_num = 3'd0;
            eye_pos = 8'd0;
            phase = lse_pkg::PH_FRAME;
            count = 8'd0;
            n_done++;
            return;
         end
         sweep_num++;
         if (open_sweep()) return;
      end
   endfunction

   function void paint(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (idx < 0 || idx >= LEDS) return;
      fr_r[idx] = r;
      fr_g[idx] = g;
      fr_b[idx] = b;
   endfunction

   function void draw_eye(int first, int dir);
      int j;
      logic [7:0] dr, dg, db;
      dr = red / 8'd10;
      dg = green / 8'd10;
      db = blue / 8'd10;
      paint(first, dr, dg, db);
      for (j = 1; j <= int'(width); j++) paint(first + dir * j, red, green, blue);
      paint(first + dir * (int'(width) + 1), dr, dg, db);
   endfunction

   function void emit_frame();
      int m;
      pixel_beat_type b;
      for (m = 0; m < LEDS; m++) begin
         fr_r[m] = 8'd0;
         fr_g[m] = 8'd0;
         fr_b[m] = 8'd0;
      end
      draw_eye(int'(eye_pos), 1);
      if (kind() == lse_pkg::KIND_O2C || kind() == lse_pkg::KIND_C2O)
         draw_eye(LEDS - int'(eye_pos), -1);
      for (m = 0; m < LEDS; m++) begin
         b = '{6'(m), fr_r[m], fr_g[m], fr_b[m], m == LEDS - 1, 1'b0};
         pixels_due.push_back(b);
      end
      n_frames++;
   endfunction

   // returns 1 unless the command was ignored
   function bit take_command(bit cmd, bit abort_in);
      int p;
      n_items++;
      if (cmd) begin
         if (busy) return 1'b0;
         busy = 1'b1;
         sweep_num = 3'd0;
         if (!open_sweep()) close_sweep();
         return 1'b1;
      end
      if (!busy) return 1'b0;
      if (phase == lse_pkg::PH_FRAME) begin
         emit_frame();
         phase = lse_pkg::PH_STEP;
         count = step_len;
         return 1'b1;
      end
      if (count > 8'd1) begin
         count--;
         return 1'b1;
      end
      count = 8'd0;
      if (phase != lse_pkg::PH_STEP) begin
         close_sweep();
         return 1'b1;
      end
      if (abort_in) begin
         n_aborts++;
         close_sweep();
         return 1'b1;
      end
      p = int'(eye_pos);
      if (kind() == lse_pkg::KIND_R2L || kind() == lse_pkg::KIND_C2O) p = p - 1;
      else p = p + 1;
      if (fits(kind(), p)) begin
         eye_pos = 8'(p);
         phase = lse_pkg::PH_FRAME;
         return 1'b1;
      end
      eye_pos = 8'd0;
      if (sweep_len != 8'd0) begin
         phase = lse_pkg::PH_SWEEP;
         count = sweep_len;
         return 1'b1;
      end
      close_sweep();
      return 1'b1;
   endfunction

   function void cmp_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_errors++;
      end
   endfunction

   function void check_pixel(logic [31:0] data, logic last_bit, logic done_bit);
      pixel_beat_type want, got;
      got = '{data[5:0], data[13:6], data[21:14], data[29:22], last_bit, done_bit};
      n_beats++;
      if (pixels_due.size() == 0) begin
         $error("result beat with nothing pending: led_index %0d", got.led_index);
         n_errors++;
         return;
      end
      want = pixels_due.pop_front();
      cmp_field("led_index", want.led_index, got.led_index);
      cmp_field("pix_red", want.red, got.red);
      cmp_field("pix_green", want.green, got.green);
      cmp_field("pix_blue", want.blue, got.blue);
      cmp_field("last_pixel", want.last_pixel, got.last_pixel);
      cmp_field("sequence_done", want.seq_done, got.seq_done);
   endfunction
endclass

module tb_led_scanner_eye_sweep;
   localparam int LEDS = lse_pkg::STRIP_LEDS_DEF;
   localparam int RANDOM_ITEMS = 90;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [2:0] REG_SPARE = 3'd6;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;   // [0] abort
   logic                           req_tuser;   // [0] cmd
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [31:0]                    rsp_tdata;   // led_index, red, green, blue
   logic                           rsp_tlast;
   logic                           rsp_tuser;   // [0] sequence_done
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [lse_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lse_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lse_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sweep_scoreboard sb = new;
   bit src_idle_en;
   bit sink_idle_en;
   int active_items;
   int cycle_count;

   led_scanner_eye_sweep #(.STRIP_LEDS(LEDS)) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_led_scanner_eye_sweep: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // result side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [7:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, val};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic load_config(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [5:0] w, input logic [7:0] sw, input logic [7:0] swp);
      csr_write(lse_pkg::REG_EYE_RED, r);
      csr_write(lse_pkg::REG_EYE_GREEN, g);
      csr_write(lse_pkg::REG_EYE_BLUE, b);
      csr_write(lse_pkg::REG_EYE_WIDTH, {2'b00, w});
      csr_write(lse_pkg::REG_STEP_WAIT, sw);
      csr_write(lse_pkg::REG_SWEEP_WAIT, swp);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_item(input bit cmd, input bit abort_bit);
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, abort_bit};
      do @(posedge clock); while (!req_tready);
      if (sb.take_command(cmd, abort_bit)) active_items++;
      @(negedge clock);
   endtask

   // all beats back, then room for a tick that walks over empty sweeps
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      bit cmd, ab, late;
      int base;
      logic [7:0] lv [3];
      logic [5:0] w;
      logic [7:0] sw, swp;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      src_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // wide eye: empty sweeps skipped, mirrored eye off the strip, abort, start while busy
      load_config(8'd255, 8'd0, 8'd9, 6'd14, 8'd1, 8'd0);
      csr_write(REG_SPARE, 8'hA5);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b0);
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);
      send_item(1'b0, 1'b1);
      send_item(1'b0, 1'b1);
      repeat (14) send_item(1'b0, 1'b0);

      // every sweep empty with no waits: done straight from the start
      settle();
      load_config(8'd0, 8'd255, 8'd255, 6'd63, 8'd0, 8'd0);
      send_item(1'b1, 1'b0);

      // zero-width eye, zero frame wait
      settle();
      load_config(8'd200, 8'd100, 8'd50, 6'd0, 8'd0, 8'd0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);

      // long frame wait, then abort on the tick that ends it
      settle();
      src_idle_en = 1'b0;
      load_config(8'd255, 8'd255, 8'd255, 6'd4, 8'd40, 8'd255);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);
      repeat (39) send_item(1'b0, 1'b0);
      send_item(1'b0, 1'b1);

      base = active_items;
      while (active_items - base < RANDOM_ITEMS) begin
         settle();
         foreach (lv[i]) begin
            case ($urandom_range(0, 3))
               0: lv[i] = 8'd0;
               1: lv[i] = 8'd255;
               default: lv[i] = 8'($urandom_range(0, 255));
            endcase
         end
         case ($urandom_range(0, 9))
            0: w = 6'd0;
            1: w = 6'd63;
            2: w = 6'($urandom_range(12, 18));
            default: w = 6'($urandom_range(1, 10));
         endcase
         sw = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 6)) : 8'($urandom_range(0, 2));
         swp = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
         load_config(lv[0], lv[1], lv[2], w, sw, swp);
         late = (active_items - base) >= RANDOM_ITEMS * 3 / 4;
         src_idle_en = !late && $urandom_range(0, 3) != 0;
         sink_idle_en = !late && $urandom_range(0, 3) != 0;
         repeat ($urandom_range(20, 40)) begin
            if (sb.busy) begin
               cmd = ($urandom_range(0, 24) == 0);
               ab = ($urandom_range(0, 9) == 0);
            end else begin
               cmd = ($urandom_range(0, 9) != 0);
               ab = 1'($urandom_range(0, 1));
            end
            send_item(cmd, ab);
         end
      end

      settle();
      if (sb.pending() != 0) begin
         $error("%0d result beats never arrived", sb.pending());
         sb.n_errors++;
      end
      $display("covered %0d input beats (%0d acted on), %0d frames, %0d finished sequences",
               sb.n_items, active_items, sb.n_frames, sb.n_done);
      $display("%0d sweeps cut short by abort, %0d result beats checked",
               sb.n_aborts, sb.n_beats);
      if (sb.n_errors == 0) begin
         $display("tb_led_scanner_eye_sweep: done, clean");
      end else begin
         $display("tb_led_scanner_eye_sweep: done, errors");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lse_pkg.sv
rtl/lse_csr.sv
rtl/lse_ctrl.sv
rtl/lse_dp.sv
rtl/led_scanner_eye_sweep.sv
sim/tb_led_scanner_eye_sweep.sv
